[hw/rtl/assert_macros.svh]
// Assertion macros used by the pressure baseline tracker core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define PBT_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("pbt assertion failed");

// Check that cons holds in the cycle after ante holds.
`define PBT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("pbt assertion failed");

`endif

[hw/rtl/pbt_pkg.sv]
// Shared widths, register indexes and divider interface types for the tracker.
`default_nettype none

package pbt_pkg;

  // Field widths
  localparam int unsigned SampleW = 24;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned ErrW    = 25;
  localparam int unsigned NormW   = 16;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned AlphaW  = 8;

  // Divider operand widths: |diff| << 12 over |span|, 16 quotient bits
  localparam int unsigned DiffW   = 26;
  localparam int unsigned SpanW   = 25;
  localparam int unsigned NormShift = 12;
  localparam int unsigned DivNW   = DiffW + NormShift;
  localparam int unsigned DivDW   = SpanW;
  localparam int unsigned QuotW   = 16;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgUpdatePeriod   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSmoothingAlpha = 1'b1;

  // Divider request from the sequencer
  typedef struct packed {
    logic             start;
    logic [DivNW-1:0] dividend;
    logic [DivDW-1:0] divisor;
  } div_req_t;

  // Divider status back to the sequencer
  typedef struct packed {
    logic             busy;
    logic             done;
    logic             ovf;
    logic [QuotW-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

[hw/rtl/pbt_div.sv]
// Restoring radix-2 divider, one quotient bit per cycle, with overflow flag.
`default_nettype none

module pbt_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pbt_pkg::div_req_t req_i,
  output pbt_pkg::div_rsp_t      rsp_o
);

  localparam int unsigned NW   = pbt_pkg::DivNW;
  localparam int unsigned DW   = pbt_pkg::DivDW;
  localparam int unsigned QW   = pbt_pkg::QuotW;
  localparam int unsigned CntW = $clog2(QW + 1);

  logic [DW-1:0]   rem_q, rem_d;
  logic [QW-1:0]   low_q, low_d;
  logic [DW-1:0]   den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic            ovf_q, ovf_d;

  logic [DW:0]     trial;
  logic            take;

  // Shift in the next dividend bit and try the subtract
  assign trial = {rem_q, low_q[QW-1]};
  assign take  = trial >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    low_d  = low_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    ovf_d  = ovf_q;
    done_d = 1'b0;
    if (req_i.start) begin
      // Load the high part; quotient of 2^16 or more means overflow
      rem_d  = DW'(req_i.dividend[NW-1:QW]);
      low_d  = req_i.dividend[QW-1:0];
      ovf_d  = DW'(req_i.dividend[NW-1:QW]) >= req_i.divisor;
      cnt_d  = CntW'(QW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = take ? DW'(trial - {1'b0, den_q}) : DW'(trial);
      low_d = {low_q[QW-2:0], take};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Hold operands and partial results
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    ovf_q <= ovf_d;
    if (req_i.start) begin
      den_q <= req_i.divisor;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = ovf_q;
  assign rsp_o.quot = low_q;

endmodule

`default_nettype wire

[hw/rtl/pressure_baseline_tracker_core.sv]
// Top level of the pressure baseline tracker: sequencer, shared multiplier, divider.
//
// Usage:
//   s_axis carries one word per sample: tdata = {time_ms[31:0], sample_pressure[23:0]}.
//   m_axis returns one word per sample with the tracker state after that sample.
//   cfg_we_i / cfg_index_i / cfg_wdata_i write update_period (0) and
//   smoothing_alpha (1); write them only while the block is idle.
// Sequencing:
//   The block takes one word at a time; s_axis_tready is high only when idle.
//   A sample that is not due for an update goes from the check step straight
//   to the output step, and once it is in the output register the block
//   returns to idle for the next word. A sample that updates the trackers runs
//   seven sequencer steps through the shared multiplier and adder, the
//   radix-2 divider (one quotient bit a cycle, then done) and the output step.
//   With zero span the divider is skipped.
// Reset:
//   rst_ni clears the trackers (peak to most negative, floor to most positive,
//   others to zero) and restores update_period 100 and smoothing_alpha 26.
// Stall:
//   A finished word waits in the output register until m_axis_tready; the next
//   input word is accepted and processed, then held until the register frees.
`default_nettype none
`include "assert_macros.svh"

module pressure_baseline_tracker_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Configuration write port
  input  wire logic                         cfg_we_i,
  input  wire logic [pbt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [15:0]                  cfg_wdata_i,
  // Sample stream
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [55:0]                  s_axis_tdata,  // sample_pressure[23:0], time_ms[55:24]
  // Result stream
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // pressure_error[24:0], smoothed_pressure[48:25], normalized_error[64:49],
  // peak_pressure[88:65], floor_pressure[112:89], zero pad[119:113]
  output logic [119:0]                      m_axis_tdata,
  output logic [1:0]                        m_axis_tuser   // updated[0], span_zero[1]
);

  localparam int unsigned SW  = pbt_pkg::SampleW;
  localparam int unsigned EW  = pbt_pkg::ErrW;
  localparam int unsigned NMW = pbt_pkg::NormW;
  localparam int unsigned FW  = pbt_pkg::DiffW;
  localparam int unsigned PW  = pbt_pkg::SpanW;
  localparam int unsigned QW  = pbt_pkg::QuotW;
  localparam int unsigned AW  = pbt_pkg::AlphaW;
  localparam int unsigned MAW = AW + 2;
  localparam int unsigned MBW = SW + 1;
  localparam int unsigned MPW = MAW + MBW;
  localparam int unsigned ACW = MPW + 1;

  // Sequencer states
  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StCheck  = 4'd1;
  localparam logic [3:0] StTrack  = 4'd2;
  localparam logic [3:0] StErr    = 4'd3;
  localparam logic [3:0] StMulB   = 4'd4;
  localparam logic [3:0] StSmooth = 4'd5;
  localparam logic [3:0] StDiff   = 4'd6;
  localparam logic [3:0] StDivGo  = 4'd7;
  localparam logic [3:0] StDiv    = 4'd8;
  localparam logic [3:0] StOut    = 4'd9;

  localparam logic signed [SW-1:0]  Max24 = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0]  Min24 = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [EW-1:0]  Max25 = {1'b0, {(EW-1){1'b1}}};
  localparam logic signed [EW-1:0]  Min25 = {1'b1, {(EW-1){1'b0}}};
  localparam logic signed [NMW-1:0] Max16 = {1'b0, {(NMW-1){1'b1}}};
  localparam logic signed [NMW-1:0] Min16 = {1'b1, {(NMW-1){1'b0}}};

  logic [3:0]                        state_q, state_d;
  logic [pbt_pkg::PeriodW-1:0]       period_q;
  logic [AW-1:0]                     alpha_q;
  logic [pbt_pkg::TimeW-1:0]         last_q, time_q;
  logic signed [SW-1:0]              sample_q;
  logic signed [SW-1:0]              peak_q, floor_q, smooth_q;
  logic signed [EW-1:0]              err_q;
  logic signed [NMW-1:0]             norm_q;
  logic signed [PW-1:0]              rel_q;
  logic signed [ACW-1:0]             acc_q;
  logic signed [FW-1:0]              diff_q;
  logic signed [PW-1:0]              span_q;
  logic                              upd_q, zero_q;
  logic                              out_valid_q;
  logic [119:0]                      out_data_q;
  logic [1:0]                        out_user_q;

  logic signed [MAW-1:0]             mul_a;
  logic signed [MBW-1:0]             mul_b;
  logic signed [MPW-1:0]             prod;
  logic [pbt_pkg::TimeW-1:0]         elapsed;
  logic signed [FW-1:0]              err_wide;
  logic signed [ACW-9:0]             acc_sh;
  logic [FW-1:0]                     diff_abs;
  logic [PW-1:0]                     span_abs;
  logic                              norm_neg;
  logic signed [NMW-1:0]             norm_new;
  logic                              out_load;
  logic                              in_acc;
  pbt_pkg::div_req_t                 div_req;
  pbt_pkg::div_rsp_t                 div_rsp;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == StIdle);
  assign out_load      = (state_q == StOut) && (!out_valid_q || m_axis_tready);

  // Shared multiplier: (256 - alpha) * smoothed, then alpha * relative
  always_comb begin
    if (state_q == StMulB) begin
      mul_a = MAW'(alpha_q);
      mul_b = rel_q;
    end else begin
      mul_a = MAW'((AW + 1)'(1 << AW) - (AW + 1)'(alpha_q));
      mul_b = MBW'(smooth_q);
    end
  end
  assign prod = mul_a * mul_b;

  assign elapsed  = time_q - last_q;
  assign err_wide = FW'(smooth_q) - FW'(rel_q);
  assign acc_sh   = acc_q[ACW-1:8];
  assign diff_abs = diff_q[FW-1] ? FW'(-diff_q) : FW'(diff_q);
  assign span_abs = span_q[PW-1] ? PW'(-span_q) : PW'(span_q);

  // Divider request: |diff| * 4096 over |span|
  assign div_req.start    = (state_q == StDivGo) && (span_q != '0);
  assign div_req.dividend = {diff_abs, {pbt_pkg::NormShift{1'b0}}};
  assign div_req.divisor  = span_abs;

  pbt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Apply sign and saturate the quotient
  assign norm_neg = diff_q[FW-1] ^ span_q[PW-1];
  always_comb begin
    if (!norm_neg) begin
      norm_new = (div_rsp.ovf || div_rsp.quot[QW-1]) ? Max16 : NMW'(div_rsp.quot);
    end else if (div_rsp.ovf || (div_rsp.quot > {1'b1, {(QW-1){1'b0}}})) begin
      norm_new = Min16;
    end else begin
      norm_new = NMW'(~div_rsp.quot + QW'(1));
    end
  end

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:   if (in_acc) state_d = StCheck;
      StCheck:  state_d = (elapsed > pbt_pkg::TimeW'(period_q)) ? StTrack : StOut;
      StTrack:  state_d = StErr;
      StErr:    state_d = StMulB;
      StMulB:   state_d = StSmooth;
      StSmooth: state_d = StDiff;
      StDiff:   state_d = StDivGo;
      StDivGo:  state_d = (span_q == '0) ? StOut : StDiv;
      StDiv:    if (div_rsp.done) state_d = StOut;
      StOut:    if (out_load) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // Control and tracker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      period_q    <= pbt_pkg::PeriodW'(100);
      alpha_q     <= AW'(26);
      last_q      <= '0;
      peak_q      <= Min24;
      floor_q     <= Max24;
      smooth_q    <= '0;
      err_q       <= '0;
      norm_q      <= '0;
      upd_q       <= 1'b0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          pbt_pkg::CfgUpdatePeriod:   period_q <= cfg_wdata_i;
          pbt_pkg::CfgSmoothingAlpha: alpha_q  <= cfg_wdata_i[AW-1:0];
          default: ;
        endcase
      end
      case (state_q)
        StCheck: begin
          upd_q  <= elapsed > pbt_pkg::TimeW'(period_q);
          zero_q <= 1'b0;
        end
        StTrack: begin
          last_q <= time_q;
          if (sample_q > peak_q) peak_q <= sample_q;
          if ((sample_q < floor_q) && (sample_q > 0)) floor_q <= sample_q;
        end
        StErr: begin
          if (err_wide[FW-1] != err_wide[FW-2]) begin
            err_q <= err_wide[FW-1] ? Min25 : Max25;
          end else begin
            err_q <= EW'(err_wide);
          end
        end
        StSmooth: begin
          if (acc_sh > (ACW - 8)'(Max24)) smooth_q <= Max24;
          else if (acc_sh < (ACW - 8)'(Min24)) smooth_q <= Min24;
          else smooth_q <= SW'(acc_sh);
        end
        StDivGo: if (span_q == '0) zero_q <= 1'b1;
        StDiv:   if (div_rsp.done) norm_q <= norm_new;
        default: ;
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath working registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= s_axis_tdata[SW-1:0];
      time_q   <= s_axis_tdata[SW +: pbt_pkg::TimeW];
    end
    case (state_q)
      StTrack:  rel_q <= PW'(sample_q) - PW'(floor_q);
      StErr:    acc_q <= ACW'(prod) + ACW'(128);
      StMulB:   acc_q <= acc_q + ACW'(prod);
      StDiff: begin
        diff_q <= FW'(smooth_q) - FW'(rel_q);
        span_q <= PW'(peak_q) - PW'(floor_q);
      end
      default: ;
    endcase
    if (out_load) begin
      out_data_q <= {7'b0, floor_q, peak_q, norm_q, smooth_q, err_q};
      out_user_q <= {zero_q, upd_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // Block takes one word at a time
  `PBT_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_acc, !s_axis_tready)
  // Divider is never started on a zero span
  `PBT_ASSERT_SAME(a_div_nonzero, clk_i, rst_ni, div_req.start, div_req.divisor != '0)
  // Divider is started only when it is free
  `PBT_ASSERT_SAME(a_div_idle, clk_i, rst_ni, div_req.start, !div_rsp.busy)
  // Zero span is flagged only on updates
  `PBT_ASSERT_SAME(a_zero_needs_upd, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[1],
                   m_axis_tuser[0])

endmodule

`default_nettype wire
